// ===== src/buck_boost_pwm_dither_mapper_defines.svh =====
// ----------------------------------------------------------------------------
// Buck-boost PWM dither mapper assertion macros
// Shared concurrent assertion wrappers, clocked on clock, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef BUCK_BOOST_PWM_DITHER_MAPPER_DEFINES_SVH
`define BUCK_BOOST_PWM_DITHER_MAPPER_DEFINES_SVH

// same-cycle implication
`define BBPDM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bbpdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buck-boost PWM dither mapper package
// Defaults, duty scaling helpers and the control bundle between stages.
// ----------------------------------------------------------------------------
package bbpdm_pkg;

   localparam int TIMER_TICKS_DEFAULT       = 1024;
   localparam int DITHER_SLOTS_LOG2_DEFAULT = 4;

   localparam int CMD_W     = 32;
   localparam int COMPARE_W = 12;
   localparam int DUTY_OUT_W = 16;
   localparam int SLOT_OUT_W = 4;

   // full scale in sub-tick units
   function automatic int full_ticks(input int ticks, input int slots_log2);
      full_ticks = ticks << slots_log2;
   endfunction

   function automatic int dead_ticks(input int ticks, input int slots_log2);
      dead_ticks = (full_ticks(ticks, slots_log2) * 2) / 100;
   endfunction

   // bootstrap-refresh ceiling: full scale less 6% reserve
   function automatic int ceil_ticks(input int ticks, input int slots_log2);
      ceil_ticks = full_ticks(ticks, slots_log2)
                 - (full_ticks(ticks, slots_log2) * 6) / 100;
   endfunction

   function automatic int max_duty(input int ticks, input int slots_log2);
      max_duty = (full_ticks(ticks, slots_log2) * 170) / 100;
   endfunction

   typedef struct packed {
      logic                  enabled;
      logic [DUTY_OUT_W-1:0] logical_duty;
   } map_ctl_type;

endpackage

// ===== src/bbpdm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buck-boost PWM dither mapper front end
// Command register, clamp, dead band and two-leg mapping.
// ----------------------------------------------------------------------------
module bbpdm_front #(
   parameter int TIMER_TICKS       = bbpdm_pkg::TIMER_TICKS_DEFAULT,
   parameter int DITHER_SLOTS_LOG2 = bbpdm_pkg::DITHER_SLOTS_LOG2_DEFAULT,
   localparam int CEIL_TICKS = bbpdm_pkg::ceil_ticks(TIMER_TICKS, DITHER_SLOTS_LOG2),
   localparam int LEG_W      = $clog2(CEIL_TICKS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [bbpdm_pkg::CMD_W-1:0] req_duty_command,
   output logic                          map_valid,
   input  logic                          map_ready,
   output bbpdm_pkg::map_ctl_type        map_ctl,
   output logic [LEG_W-1:0]              map_boost,
   output logic [LEG_W-1:0]              map_buck
);

   localparam int DEAD_TICKS = bbpdm_pkg::dead_ticks(TIMER_TICKS, DITHER_SLOTS_LOG2);
   localparam int MAX_DUTY   = bbpdm_pkg::max_duty(TIMER_TICKS, DITHER_SLOTS_LOG2);
   localparam int CAP_DUTY   = MAX_DUTY - DEAD_TICKS;
   localparam int DUTY_W     = $clog2(2 * CEIL_TICKS + 1);

   logic                        cmd_valid_ff, cmd_valid_in;
   logic [bbpdm_pkg::CMD_W-1:0] cmd_ff;
   logic                        accept;
   logic [DUTY_W-1:0]           duty;
   logic [DUTY_W-1:0]           hw_duty;
   logic [DUTY_W-1:0]           boost_raw;
   logic [31:0]                 duty_ext;
   logic                        enabled;

   assign req_stall = cmd_valid_ff && !map_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         cmd_valid_in = 1'b1;
      end else if (map_ready) begin
         cmd_valid_in = 1'b0;
      end else begin
         cmd_valid_in = cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_duty_command;
      end
   end

   // clamp to 0..max duty
   always_comb begin
      priority if (cmd_ff[bbpdm_pkg::CMD_W-1]) begin
         duty = '0;
      end else if (cmd_ff[bbpdm_pkg::CMD_W-2:0] > (bbpdm_pkg::CMD_W-1)'(MAX_DUTY)) begin
         duty = DUTY_W'(MAX_DUTY);
      end else begin
         duty = cmd_ff[DUTY_W-1:0];
      end
   end

   assign enabled   = (duty >= DUTY_W'(DEAD_TICKS));
   assign hw_duty   = (duty > DUTY_W'(CAP_DUTY)) ? DUTY_W'(CAP_DUTY) : duty;
   // 2*ceil exceeds the cap, so this never goes negative
   assign boost_raw = DUTY_W'(2 * CEIL_TICKS) - hw_duty;

   always_comb begin
      if (!enabled) begin
         map_boost = '0;
         map_buck  = '0;
      end else begin
         map_boost = (boost_raw > DUTY_W'(CEIL_TICKS)) ? LEG_W'(CEIL_TICKS)
                                                       : boost_raw[LEG_W-1:0];
         map_buck  = (hw_duty > DUTY_W'(CEIL_TICKS)) ? LEG_W'(CEIL_TICKS)
                                                     : hw_duty[LEG_W-1:0];
      end
   end

   assign duty_ext             = 32'(duty);
   assign map_ctl.enabled      = enabled;
   assign map_ctl.logical_duty = duty_ext[bbpdm_pkg::DUTY_OUT_W-1:0];
   assign map_valid            = cmd_valid_ff;

endmodule

// ===== src/bbpdm_dither.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buck-boost PWM dither mapper slot emitter
// Holds one mapped transaction and emits its dither slots through an
// output register, one slot per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
`include "buck_boost_pwm_dither_mapper_defines.svh"

module bbpdm_dither #(
   parameter int TIMER_TICKS       = bbpdm_pkg::TIMER_TICKS_DEFAULT,
   parameter int DITHER_SLOTS_LOG2 = bbpdm_pkg::DITHER_SLOTS_LOG2_DEFAULT,
   localparam int CEIL_TICKS = bbpdm_pkg::ceil_ticks(TIMER_TICKS, DITHER_SLOTS_LOG2),
   localparam int LEG_W      = $clog2(CEIL_TICKS + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                map_valid,
   output logic                                map_ready,
   input  bbpdm_pkg::map_ctl_type              map_ctl,
   input  logic [LEG_W-1:0]                    map_boost,
   input  logic [LEG_W-1:0]                    map_buck,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bbpdm_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   output logic [bbpdm_pkg::COMPARE_W-1:0]     rsp_boost_leg_compare,
   output logic [bbpdm_pkg::COMPARE_W-1:0]     rsp_buck_leg_compare,
   output logic                                rsp_outputs_enabled,
   output logic [bbpdm_pkg::DUTY_OUT_W-1:0]    rsp_logical_duty,
   output logic                                rsp_last_slot
);

   localparam int L = DITHER_SLOTS_LOG2;

   logic                   run_valid_ff, run_valid_in;
   bbpdm_pkg::map_ctl_type run_ctl_ff;
   logic [LEG_W-1:0]       run_boost_ff, run_buck_ff;
   logic [L-1:0]           slot_ff, slot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [bbpdm_pkg::SLOT_OUT_W-1:0] slot_index_ff;
   logic [bbpdm_pkg::COMPARE_W-1:0]  boost_cmp_ff, buck_cmp_ff;
   logic                   enabled_ff;
   logic [bbpdm_pkg::DUTY_OUT_W-1:0] duty_ff;
   logic                   last_ff;

   logic                   out_load, emit, last_now, run_done, run_load;
   logic [LEG_W-1:0]       boost_base, buck_base;
   logic                   boost_bump, buck_bump;
   logic [31:0]            boost_word, buck_word, slot_ext;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign emit      = run_valid_ff && out_load;
   assign last_now  = (slot_ff == {L{1'b1}});
   assign run_done  = emit && last_now;
   assign map_ready = !run_valid_ff || run_done;
   assign run_load  = map_valid && map_ready;

   always_comb begin
      if (run_load) begin
         run_valid_in = 1'b1;
      end else if (run_done) begin
         run_valid_in = 1'b0;
      end else begin
         run_valid_in = run_valid_ff;
      end
   end

   always_comb begin
      if (run_load) begin
         slot_in = '0;
      end else if (emit) begin
         slot_in = slot_ff + L'(1);
      end else begin
         slot_in = slot_ff;
      end
   end

   assign rsp_valid_in = out_load ? run_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         run_valid_ff <= run_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (run_load) begin
         run_ctl_ff   <= map_ctl;
         run_boost_ff <= map_boost;
         run_buck_ff  <= map_buck;
      end
   end

   // slot i gets base+1 while i is below the fractional part
   assign boost_base = run_boost_ff >> L;
   assign buck_base  = run_buck_ff >> L;
   assign boost_bump = (slot_ff < run_boost_ff[L-1:0]);
   assign buck_bump  = (slot_ff < run_buck_ff[L-1:0]);
   assign boost_word = 32'(boost_base) + 32'(boost_bump);
   assign buck_word  = 32'(buck_base) + 32'(buck_bump);
   assign slot_ext   = 32'(slot_ff);

   always_ff @(posedge clock) begin
      if (emit) begin
         slot_index_ff <= slot_ext[bbpdm_pkg::SLOT_OUT_W-1:0];
         boost_cmp_ff  <= boost_word[bbpdm_pkg::COMPARE_W-1:0];
         buck_cmp_ff   <= buck_word[bbpdm_pkg::COMPARE_W-1:0];
         enabled_ff    <= run_ctl_ff.enabled;
         duty_ff       <= run_ctl_ff.logical_duty;
         last_ff       <= last_now;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_slot_index        = slot_index_ff;
   assign rsp_boost_leg_compare = boost_cmp_ff;
   assign rsp_buck_leg_compare  = buck_cmp_ff;
   assign rsp_outputs_enabled   = enabled_ff;
   assign rsp_logical_duty      = duty_ff;
   assign rsp_last_slot         = last_ff;

   // a run continues without a gap once a non-final slot is taken
   `BBPDM_ASSERT_NEXT(a_slot_follows, rsp_valid_ff && !rsp_stall && !last_ff, rsp_valid_ff && slot_index_ff == $past(slot_index_ff) + 4'd1, "dither slot sequence broken")

   `BBPDM_ASSERT_NEXT(a_run_stable, rsp_valid_ff && !rsp_stall && !last_ff, $stable(enabled_ff) && $stable(duty_ff), "run fields changed mid-run")

   `BBPDM_ASSERT_NOW(a_dead_band_zero, rsp_valid_ff && !enabled_ff, boost_cmp_ff == '0 && buck_cmp_ff == '0, "nonzero compare with outputs disabled")

   `BBPDM_ASSERT_NOW(a_no_overwrite, run_load, !run_valid_ff || run_done, "run register overwritten while busy")

endmodule

// ===== src/buck_boost_pwm_dither_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buck-boost PWM dither mapper
// Clamps a signed duty command, maps it onto boost and buck legs under a
// bootstrap-refresh ceiling and emits each leg as a dither table of
// compare words, one slot per transaction.
//
//   channel | prefix | direction | per transaction
//   --------+--------+-----------+---------------------------------------
//   request | req_   | in        | one duty command
//   result  | rsp_   | out       | one dither slot, 2**DITHER_SLOTS_LOG2 per command
//
// Each command yields 2**DITHER_SLOTS_LOG2 results (16 by default), one per
// cycle while rsp_stall is low; the slot counter in the emitter sets the
// sustained command rate.
// The first result passes the input register, the run register and the output
// register; a following command waits in the input register and its first slot
// follows the last slot of the previous run with no idle cycle.
// rsp_stall holds the output register; req_stall rises while the input
// register and the run register are occupied, unless the last slot is emitted.
// Synchronous active-high reset clears all valid flags and the slot counter.
// ----------------------------------------------------------------------------
module buck_boost_pwm_dither_mapper #(
   parameter int TIMER_TICKS       = bbpdm_pkg::TIMER_TICKS_DEFAULT,
   parameter int DITHER_SLOTS_LOG2 = bbpdm_pkg::DITHER_SLOTS_LOG2_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [bbpdm_pkg::CMD_W-1:0]  req_duty_command,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bbpdm_pkg::SLOT_OUT_W-1:0]    rsp_slot_index,
   output logic [bbpdm_pkg::COMPARE_W-1:0]     rsp_boost_leg_compare,
   output logic [bbpdm_pkg::COMPARE_W-1:0]     rsp_buck_leg_compare,
   output logic                                rsp_outputs_enabled,
   output logic [bbpdm_pkg::DUTY_OUT_W-1:0]    rsp_logical_duty,
   output logic                                rsp_last_slot
);

   localparam int CEIL_TICKS = bbpdm_pkg::ceil_ticks(TIMER_TICKS, DITHER_SLOTS_LOG2);
   localparam int LEG_W      = $clog2(CEIL_TICKS + 1);

   logic                   map_valid, map_ready;
   bbpdm_pkg::map_ctl_type map_ctl;
   logic [LEG_W-1:0]       map_boost, map_buck;

   bbpdm_front #(
      .TIMER_TICKS       (TIMER_TICKS),
      .DITHER_SLOTS_LOG2 (DITHER_SLOTS_LOG2)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_duty_command (req_duty_command),
      .map_valid        (map_valid),
      .map_ready        (map_ready),
      .map_ctl          (map_ctl),
      .map_boost        (map_boost),
      .map_buck         (map_buck)
   );

   bbpdm_dither #(
      .TIMER_TICKS       (TIMER_TICKS),
      .DITHER_SLOTS_LOG2 (DITHER_SLOTS_LOG2)
   ) u_dither (
      .clock                 (clock),
      .reset                 (reset),
      .map_valid             (map_valid),
      .map_ready             (map_ready),
      .map_ctl               (map_ctl),
      .map_boost             (map_boost),
      .map_buck              (map_buck),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_slot_index        (rsp_slot_index),
      .rsp_boost_leg_compare (rsp_boost_leg_compare),
      .rsp_buck_leg_compare  (rsp_buck_leg_compare),
      .rsp_outputs_enabled   (rsp_outputs_enabled),
      .rsp_logical_duty      (rsp_logical_duty),
      .rsp_last_slot         (rsp_last_slot)
   );

endmodule
